@@ rtl/sars_pkg.sv @@
package sars_pkg;

   localparam int MAX_THREADS = 16;
   localparam int SLOT_W      = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
   localparam int COUNT_W     = $clog2(MAX_THREADS + 1);
   localparam int MS_W        = 32;
   localparam int CMD_W       = 3;
   localparam int OUT_SLOT_W  = 4;
   localparam int OUT_COUNT_W = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK   = 3'd0,
      CMD_ADD    = 3'd1,
      CMD_SLEEP  = 3'd2,
      CMD_KILL   = 3'd3,
      CMD_LAUNCH = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SEARCH,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic capture;
      logic execute;
      logic search;
      logic finish;
   } ctl_type;

   typedef struct packed {
      logic out_busy;
   } sts_type;

   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] slot;
   } hit_type;

   // first set bit of mask at or after start, in ring order
   function automatic hit_type find_from(input logic [MAX_THREADS-1:0] mask,
                                         input logic [SLOT_W-1:0]      start);
      logic [2*MAX_THREADS-1:0] dbl;
      logic [MAX_THREADS-1:0]   rot;
      logic [SLOT_W-1:0]        pos;
      logic [SLOT_W:0]          sum;
      hit_type                  hit;
      dbl = {mask, mask} >> start;
      rot = dbl[MAX_THREADS-1:0];
      pos = '0;
      for (int i = MAX_THREADS - 1; i >= 0; i--) begin
         if (rot[i]) begin
            pos = SLOT_W'(i);
         end
      end
      sum = {1'b0, start} + {1'b0, pos};
      if (sum >= (SLOT_W+1)'(MAX_THREADS)) begin
         sum = sum - (SLOT_W+1)'(MAX_THREADS);
      end
      hit.found = |mask;
      hit.slot  = sum[SLOT_W-1:0];
      return hit;
   endfunction

endpackage

@@ rtl/sars_ctrl.sv @@
module sars_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sars_pkg::sts_type sts,
   output sars_pkg::ctl_type ctl
);
   import sars_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            ctl.execute = 1'b1;
            state_in    = ST_SEARCH;
         end
         ST_SEARCH: begin
            ctl.search = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            if (!sts.out_busy) begin
               ctl.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_one_step: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl.capture, ctl.execute, ctl.search, ctl.finish}))
      else $error("more than one step command");

   a_exec_follows: assert property (@(posedge clock) disable iff (reset)
      ctl.capture |=> ctl.execute ##1 ctl.search)
      else $error("sequence broken after capture");

   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.finish |=> req_ready)
      else $error("not ready after finish");

endmodule

@@ rtl/sars_datapath.sv @@
module sars_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sars_pkg::ctl_type                    ctl,
   output sars_pkg::sts_type                    sts,
   input  logic [sars_pkg::CMD_W-1:0]           req_command,
   input  logic [sars_pkg::MS_W-1:0]            req_sleep_ms,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [sars_pkg::OUT_SLOT_W-1:0]      rsp_current_thread,
   output logic                                 rsp_idle,
   output logic                                 rsp_added_ok,
   output logic [sars_pkg::OUT_SLOT_W-1:0]      rsp_added_slot,
   output logic [sars_pkg::OUT_COUNT_W-1:0]     rsp_thread_count
);
   import sars_pkg::*;

   cmd_type                 cmd_ff;
   logic [MS_W-1:0]         ms_ff;

   logic [MS_W-1:0]         sleep_ff [MAX_THREADS];
   logic [MS_W-1:0]         sleep_in [MAX_THREADS];
   logic [MAX_THREADS-1:0]  valid_ff,    valid_in;
   logic [SLOT_W-1:0]       running_ff,  running_in;
   logic                    launched_ff, launched_in;
   logic [SLOT_W-1:0]       newest_ff,   newest_in;
   logic [COUNT_W-1:0]      count_ff,    count_in;
   logic                    ok_ff,       ok_in;
   logic [SLOT_W-1:0]       slot_ff,     slot_in;
   logic                    search_ff,   search_in;
   logic                    mode_ff,     mode_in;   // 1: launch search over valid slots

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]       rsp_cur_ff;
   logic                    rsp_idle_ff;
   logic                    rsp_ok_ff;
   logic [SLOT_W-1:0]       rsp_slot_ff;
   logic [COUNT_W-1:0]      rsp_count_ff;

   logic [MAX_THREADS-1:0]  awake;
   hit_type                 free_hit;
   hit_type                 next_hit;
   logic [SLOT_W-1:0]       run_next;
   logic                    run_live;

   always_comb begin
      for (int i = 0; i < MAX_THREADS; i++) begin
         awake[i] = valid_ff[i] && (sleep_ff[i] == '0);
      end
   end

   assign free_hit = find_from(~valid_ff, '0);
   assign run_next = (running_ff == SLOT_W'(MAX_THREADS - 1)) ? '0 : running_ff + 1'b1;
   assign next_hit = mode_ff ? find_from(valid_ff, newest_ff) : find_from(awake, run_next);
   assign run_live = launched_ff && valid_ff[running_ff];

   always_comb begin
      sleep_in    = sleep_ff;
      valid_in    = valid_ff;
      running_in  = running_ff;
      launched_in = launched_ff;
      newest_in   = newest_ff;
      count_in    = count_ff;
      ok_in       = ok_ff;
      slot_in     = slot_ff;
      search_in   = search_ff;
      mode_in     = mode_ff;
      if (ctl.execute) begin
         ok_in     = 1'b0;
         slot_in   = '0;
         search_in = 1'b0;
         mode_in   = 1'b0;
         case (cmd_ff)
            CMD_TICK: begin
               for (int i = 0; i < MAX_THREADS; i++) begin
                  if (sleep_ff[i] != '0) begin
                     sleep_in[i] = sleep_ff[i] - 1'b1;
                  end
               end
               search_in = launched_ff;
            end
            CMD_ADD: begin
               if (free_hit.found) begin
                  valid_in[free_hit.slot] = 1'b1;
                  sleep_in[free_hit.slot] = '0;
                  newest_in               = free_hit.slot;
                  count_in                = count_ff + 1'b1;
                  ok_in                   = 1'b1;
                  slot_in                 = free_hit.slot;
               end
            end
            CMD_SLEEP: begin
               if (run_live) begin
                  sleep_in[running_ff] = ms_ff;
                  search_in            = 1'b1;
               end
            end
            CMD_KILL: begin
               if (run_live) begin
                  valid_in[running_ff] = 1'b0;
                  sleep_in[running_ff] = '0;
                  count_in             = count_ff - 1'b1;
                  search_in            = 1'b1;
               end
            end
            CMD_LAUNCH: begin
               if (!launched_ff && (valid_ff != '0)) begin
                  launched_in = 1'b1;
                  search_in   = 1'b1;
                  mode_in     = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
      if (ctl.search && search_ff && next_hit.found) begin
         running_in = next_hit.slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_THREADS; i++) begin
            sleep_ff[i] <= '0;
         end
         valid_ff    <= '0;
         running_ff  <= '0;
         launched_ff <= 1'b0;
         newest_ff   <= '0;
         count_ff    <= '0;
         search_ff   <= 1'b0;
         mode_ff     <= 1'b0;
      end else begin
         sleep_ff    <= sleep_in;
         valid_ff    <= valid_in;
         running_ff  <= running_in;
         launched_ff <= launched_in;
         newest_ff   <= newest_in;
         count_ff    <= count_in;
         search_ff   <= search_in;
         mode_ff     <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      ok_ff   <= ok_in;
      slot_ff <= slot_in;
      if (ctl.capture) begin
         cmd_ff <= cmd_type'(req_command);
         ms_ff  <= req_sleep_ms;
      end
   end

   // output register
   assign sts.out_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid_in = ctl.finish ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.finish) begin
         rsp_cur_ff   <= running_ff;
         rsp_idle_ff  <= !(launched_ff && awake[running_ff]);
         rsp_ok_ff    <= ok_ff;
         rsp_slot_ff  <= slot_ff;
         rsp_count_ff <= count_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_current_thread = OUT_SLOT_W'(rsp_cur_ff);
   assign rsp_idle           = rsp_idle_ff;
   assign rsp_added_ok       = rsp_ok_ff;
   assign rsp_added_slot     = OUT_SLOT_W'(rsp_slot_ff);
   assign rsp_thread_count   = OUT_COUNT_W'(rsp_count_ff);

   a_count_match: assert property (@(posedge clock) disable iff (reset)
      count_ff == COUNT_W'($countones(valid_ff)))
      else $error("thread count out of step with valid slots");

   a_launch_sticky: assert property (@(posedge clock) disable iff (reset)
      launched_ff |=> launched_ff)
      else $error("launched flag cleared");

   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ok_ff) |-> (rsp_slot_ff == '0))
      else $error("added slot nonzero without add");

   a_busy_hold: assert property (@(posedge clock) disable iff (reset)
      sts.out_busy |-> !ctl.finish)
      else $error("result overwritten while pending");

endmodule

@@ rtl/sleep_aware_round_robin_scheduler.sv @@
// Round-robin thread-slot scheduler with per-slot sleep counters (16 slots).
// Each transaction (tick, add, sleep, kill, launch) runs the controller steps
// capture, execute, ring search for the next awake slot (on launch, the
// newest added slot), and load of the output register. One transaction is
// handled at a time. The result stays in the output register until taken,
// and the next transaction may be accepted meanwhile; its final step waits
// only if the previous result is still pending. No clearing pass after
// reset: the block takes transactions from the first cycle.
module sleep_aware_round_robin_scheduler (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [sars_pkg::CMD_W-1:0]       req_command,
   input  logic [sars_pkg::MS_W-1:0]        req_sleep_ms,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [sars_pkg::OUT_SLOT_W-1:0]  rsp_current_thread,
   output logic                             rsp_idle,
   output logic                             rsp_added_ok,
   output logic [sars_pkg::OUT_SLOT_W-1:0]  rsp_added_slot,
   output logic [sars_pkg::OUT_COUNT_W-1:0] rsp_thread_count
);
   import sars_pkg::*;

   ctl_type ctl;
   sts_type sts;

   sars_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   sars_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .ctl                (ctl),
      .sts                (sts),
      .req_command        (req_command),
      .req_sleep_ms       (req_sleep_ms),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_current_thread (rsp_current_thread),
      .rsp_idle           (rsp_idle),
      .rsp_added_ok       (rsp_added_ok),
      .rsp_added_slot     (rsp_added_slot),
      .rsp_thread_count   (rsp_thread_count)
   );

endmodule
